/* design/efp_pkg.sv */
// Package for the escape-time fractal pixel unit.
// Holds the register map, the configuration bundle, the sequencer states and
// the Q4.28 saturation helper. No dependencies.
package efp_pkg;

  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned FIX_W       = 32;
  localparam int unsigned PROD_W      = 64;
  localparam int unsigned ITER_W      = 16;
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned FRAC_BITS   = 28;

  localparam logic signed [FIX_W-1:0] JULIA_C = 32'sd96636764;
  localparam logic signed [PROD_W-1:0] FIX_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] FIX_MIN = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_RE    = 8'd0,
    CFG_START_IM    = 8'd1,
    CFG_STEP_RE     = 8'd2,
    CFG_STEP_IM     = 8'd3,
    CFG_MAX_ITER    = 8'd4,
    CFG_BAILOUT     = 8'd5,
    CFG_COLOR_SCALE = 8'd6,
    CFG_MODE        = 8'd7
  } efp_cfg_idx_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] start_re;
    logic signed [FIX_W-1:0] start_im;
    logic signed [FIX_W-1:0] step_re;
    logic signed [FIX_W-1:0] step_im;
    logic [ITER_W-1:0]       max_iter;
    logic [FIX_W-1:0]        bailout;
    logic [FIX_W-1:0]        color_scale;
    logic                    julia;
  } efp_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_MAP_END,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE,
    ST_COLOR,
    ST_EMIT
  } efp_state_t;

  function automatic logic signed [FIX_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [FIX_W-1:0] r;
    if (v > FIX_MAX) begin
      r = FIX_MAX[FIX_W-1:0];
    end else if (v < FIX_MIN) begin
      r = FIX_MIN[FIX_W-1:0];
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/efp_cfg_regs.sv */
// Configuration register file of the escape-time fractal pixel unit.
// Depends on efp_pkg for the register map and the configuration bundle.
module efp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [efp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [efp_pkg::FIX_W-1:0]       cfg_data,
  output efp_pkg::efp_cfg_t               cfg
);

  efp_pkg::efp_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_re    <= -32'sd536870912;
      cfg_r.start_im    <= 32'sd268435456;
      cfg_r.step_re     <= 32'sd786432;
      cfg_r.step_im     <= 32'sd524288;
      cfg_r.max_iter    <= 16'd255;
      cfg_r.bailout     <= 32'd67108864;
      cfg_r.color_scale <= 32'd1;
      cfg_r.julia       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        efp_pkg::CFG_START_RE:    cfg_r.start_re    <= cfg_data;
        efp_pkg::CFG_START_IM:    cfg_r.start_im    <= cfg_data;
        efp_pkg::CFG_STEP_RE:     cfg_r.step_re     <= cfg_data;
        efp_pkg::CFG_STEP_IM:     cfg_r.step_im     <= cfg_data;
        efp_pkg::CFG_MAX_ITER:    cfg_r.max_iter    <= cfg_data[efp_pkg::ITER_W-1:0];
        efp_pkg::CFG_BAILOUT:     cfg_r.bailout     <= cfg_data;
        efp_pkg::CFG_COLOR_SCALE: cfg_r.color_scale <= cfg_data;
        efp_pkg::CFG_MODE:        cfg_r.julia       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* design/efp_mult.sv */
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
// Depends on efp_pkg for the operand and product widths.
module efp_mult (
  input  logic                                clk,
  input  logic signed [efp_pkg::FIX_W-1:0]    op_a,
  input  logic signed [efp_pkg::FIX_W-1:0]    op_b,
  output logic signed [efp_pkg::PROD_W-1:0]   prod
);

  logic signed [efp_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

/* design/efp_engine.sv */
// Sequencer and datapath that map a pixel to a point and run the escape loop.
// Depends on efp_pkg and on efp_mult, its single shared multiplier.
module efp_engine #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  efp_pkg::efp_cfg_t                   cfg,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [efp_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [efp_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int unsigned CW = efp_pkg::COORD_W;

  efp_pkg::efp_state_t state_r, state_nxt;

  logic [CW-1:0]                      col_r, row_r;
  logic signed [efp_pkg::FIX_W-1:0]   zr_r, zi_r, cr_r, ci_r;
  logic signed [efp_pkg::PROD_W-1:0]  rr_r, ii_r;
  logic [efp_pkg::ITER_W-1:0]         count_r;
  logic                               first_r, escaped_r;
  logic                               out_valid_r;
  logic [efp_pkg::OUT_DATA_W-1:0]     out_data_r;

  logic signed [efp_pkg::FIX_W-1:0]   op_a, op_b;
  logic signed [efp_pkg::PROD_W-1:0]  prod;
  logic                               in_fire, in_view, is_escape, at_limit, emit_ok;
  logic [efp_pkg::PROD_W-1:0]         mag, limit;
  logic signed [efp_pkg::PROD_W-1:0]  map_re, map_im, upd_re, upd_im;
  logic signed [efp_pkg::FIX_W-1:0]   map_im_sat;

  efp_mult u_mult (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign in_fire = in_tvalid && in_tready;
  assign in_view = (32'(in_tdata[CW-1:0]) < 32'(MAX_COLS))
                && (32'(in_tdata[2*CW-1:CW]) < 32'(MAX_ROWS));

  assign mag       = $unsigned(rr_r) + $unsigned(prod);
  assign limit     = {cfg.bailout, 32'd0};
  assign is_escape = !first_r && (mag > limit);
  assign at_limit  = !first_r && (count_r == cfg.max_iter);
  assign emit_ok   = !out_valid_r || out_tready;

  assign map_re     = 64'(cfg.start_re) + prod;
  assign map_im     = 64'(cfg.start_im) - prod;
  assign map_im_sat = efp_pkg::sat32(map_im);
  assign upd_re     = ((rr_r - ii_r) >>> efp_pkg::FRAC_BITS) + 64'(cr_r);
  assign upd_im     = (prod >>> (efp_pkg::FRAC_BITS - 1)) + 64'(ci_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      efp_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = in_view ? efp_pkg::ST_MAP_RE : efp_pkg::ST_EMIT;
      end
      efp_pkg::ST_MAP_RE:  state_nxt = efp_pkg::ST_MAP_IM;
      efp_pkg::ST_MAP_IM:  state_nxt = efp_pkg::ST_MAP_END;
      efp_pkg::ST_MAP_END: state_nxt = efp_pkg::ST_MUL_RR;
      efp_pkg::ST_MUL_RR:  state_nxt = efp_pkg::ST_MUL_II;
      efp_pkg::ST_MUL_II:  state_nxt = efp_pkg::ST_MUL_RI;
      efp_pkg::ST_MUL_RI: begin
        if (is_escape) begin
          state_nxt = efp_pkg::ST_COLOR;
        end else if (at_limit) begin
          state_nxt = efp_pkg::ST_EMIT;
        end else begin
          state_nxt = efp_pkg::ST_UPDATE;
        end
      end
      efp_pkg::ST_UPDATE: state_nxt = efp_pkg::ST_MUL_RR;
      efp_pkg::ST_COLOR:  state_nxt = efp_pkg::ST_EMIT;
      efp_pkg::ST_EMIT: begin
        if (emit_ok) state_nxt = efp_pkg::ST_IDLE;
      end
      default: state_nxt = efp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_a = zr_r;
    op_b = zr_r;
    unique case (state_r)
      efp_pkg::ST_MAP_RE: begin
        op_a = $signed({{(efp_pkg::FIX_W-CW){1'b0}}, col_r});
        op_b = cfg.step_re;
      end
      efp_pkg::ST_MAP_IM: begin
        op_a = $signed({{(efp_pkg::FIX_W-CW){1'b0}}, row_r});
        op_b = cfg.step_im;
      end
      efp_pkg::ST_MUL_II: begin
        op_a = zi_r;
        op_b = zi_r;
      end
      efp_pkg::ST_MUL_RI: begin
        op_a = zr_r;
        op_b = zi_r;
      end
      efp_pkg::ST_COLOR: begin
        op_a = $signed(cfg.color_scale);
        op_b = $signed({{(efp_pkg::FIX_W-efp_pkg::ITER_W){1'b0}}, count_r});
      end
      efp_pkg::ST_EMIT: begin
        op_a = $signed(cfg.color_scale);
        op_b = $signed({{(efp_pkg::FIX_W-efp_pkg::ITER_W){1'b0}}, count_r});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= efp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == efp_pkg::ST_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      efp_pkg::ST_IDLE: begin
        col_r     <= in_tdata[CW-1:0];
        row_r     <= in_tdata[2*CW-1:CW];
        escaped_r <= 1'b0;
      end
      efp_pkg::ST_MAP_IM: begin
        zr_r <= efp_pkg::sat32(map_re);
      end
      efp_pkg::ST_MAP_END: begin
        zi_r    <= map_im_sat;
        cr_r    <= cfg.julia ? efp_pkg::JULIA_C : zr_r;
        ci_r    <= cfg.julia ? efp_pkg::JULIA_C : map_im_sat;
        count_r <= '0;
        first_r <= 1'b1;
      end
      efp_pkg::ST_MUL_II: begin
        rr_r <= prod;
      end
      efp_pkg::ST_MUL_RI: begin
        ii_r      <= prod;
        escaped_r <= is_escape;
      end
      efp_pkg::ST_UPDATE: begin
        zr_r <= efp_pkg::sat32(upd_re);
        zi_r <= efp_pkg::sat32(upd_im);
        if (first_r) begin
          first_r <= 1'b0;
        end else begin
          count_r <= count_r + 16'd1;
        end
      end
      efp_pkg::ST_EMIT: begin
        if (emit_ok) begin
          out_data_r <= {7'd0, escaped_r,
                         escaped_r ? count_r : 16'd0,
                         escaped_r ? prod[efp_pkg::FIX_W-1:0] : 32'd0};
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == efp_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/escape_time_fractal_pixel_unit.sv */
// Top level of the escape-time fractal pixel unit (Mandelbrot and Julia).
// Depends on efp_pkg, efp_cfg_regs and efp_engine.
//
//   channel  direction  handshake             payload
//   in_      slave      in_tvalid/in_tready   in_tdata: column, row
//   out_     master     out_tvalid/out_tready out_tdata: pixel_color, escape_count, escaped
//   cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A pixel in the view is mapped to a point and iterated until it escapes or reaches
// max_iter, passing ST_COLOR if it escapes; the unit is ready again once ST_EMIT loads
// the result. The single shared multiplier forms three products per iteration.
// Pixels outside the view go straight to ST_EMIT. Reset is synchronous and restores the
// register defaults. The unit takes a new pixel while a finished result waits in
// the output register; it only holds a result back when that register is still full.
module escape_time_fractal_pixel_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [efp_pkg::IN_DATA_W-1:0]      in_tdata,   // column[9:0], row[19:10]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [efp_pkg::OUT_DATA_W-1:0]     out_tdata,  // pixel_color[31:0],
                                                         // escape_count[47:32], escaped[48]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [efp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [efp_pkg::FIX_W-1:0]          cfg_data
);

  efp_pkg::efp_cfg_t cfg;

  efp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  efp_engine #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for escape_time_fractal_pixel_unit.
// Predicts every pixel's colour, escape count and escape flag in Q4.28 arithmetic
// and compares each result transfer. Depends on efp_pkg and the unit itself.
module tb_top;

  typedef struct packed {
    logic signed [31:0] start_re;
    logic signed [31:0] start_im;
    logic signed [31:0] step_re;
    logic signed [31:0] step_im;
    logic [15:0]        max_iter;
    logic [31:0]        bailout;
    logic [31:0]        color_scale;
    logic               julia;
  } view_cfg_t;

  typedef struct packed {
    logic [31:0] color;
    logic [15:0] count;
    logic        escaped;
  } pixel_result_t;

  localparam view_cfg_t RESET_VIEW = '{
    start_re: -32'sd536870912, start_im: 32'sd268435456,
    step_re: 32'sd786432, step_im: 32'sd524288, max_iter: 16'd255,
    bailout: 32'd67108864, color_scale: 32'd1, julia: 1'b0
  };
  localparam logic [31:0] BAILOUT_FOUR = 32'd67108864;
  localparam longint JULIA_PART = 64'sd96636764;
  localparam longint Q428_HI = 64'sd2147483647;
  localparam longint Q428_LO = -64'sd2147483648;
  localparam logic [efp_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 8'd8;
  localparam logic [efp_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 8'hFF;
  localparam int unsigned STALL_LIMIT = 50000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [efp_pkg::IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [efp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [efp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [efp_pkg::FIX_W-1:0] cfg_data;

  view_cfg_t cur_view = RESET_VIEW;
  pixel_result_t pending_pixels[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_left = 0;
  int unsigned rx_hold_req = 0;
  bit idle_on = 1'b1;

  always #1 clk = ~clk;

  escape_time_fractal_pixel_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic longint clamp_q428(input longint v);
    if (v > Q428_HI) begin
      return Q428_HI;
    end
    if (v < Q428_LO) begin
      return Q428_LO;
    end
    return v;
  endfunction

  function automatic pixel_result_t escape_pixel(input view_cfg_t v, input logic [9:0] col,
                                                 input logic [9:0] row);
    longint zr, zi, cr, ci, nr, ni;
    logic [63:0] mag, lim;
    int unsigned n;
    pixel_result_t res;
    res = '0;
    zr = clamp_q428(longint'(v.start_re) + longint'(col) * longint'(v.step_re));
    zi = clamp_q428(longint'(v.start_im) - longint'(row) * longint'(v.step_im));
    if (v.julia) begin
      cr = JULIA_PART;
      ci = JULIA_PART;
    end else begin
      cr = zr;
      ci = zi;
    end
    lim = {v.bailout, 32'd0};
    for (n = 0; n <= v.max_iter; n++) begin
      nr = clamp_q428(((zr * zr - zi * zi) >>> efp_pkg::FRAC_BITS) + cr);
      ni = clamp_q428(((zr * zi) >>> (efp_pkg::FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      mag = zr * zr + zi * zi;
      if (mag > lim) begin
        res.color = v.color_scale * n;
        res.count = n[15:0];
        res.escaped = 1'b1;
        return res;
      end
    end
    return res;
  endfunction

  function automatic view_cfg_t random_view();
    view_cfg_t v;
    if ($urandom_range(0, 7) == 0) begin
      v.start_re = $urandom();
      v.start_im = $urandom();
      v.step_re = $urandom();
      v.step_im = $urandom();
    end else begin
      v.start_re = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
      v.start_im = $urandom_range(0, 32'h2000_0000) - 32'h0800_0000;
      v.step_re = $urandom_range(32'h1_0000, 32'h10_0000);
      v.step_im = $urandom_range(32'h1_0000, 32'h10_0000);
    end
    v.max_iter = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300))
                                              : 16'($urandom_range(0, 127));
    v.bailout = ($urandom_range(0, 3) == 0) ? $urandom() : BAILOUT_FOUR;
    v.color_scale = $urandom();
    v.julia = 1'($urandom_range(0, 1));
    return v;
  endfunction

  task automatic write_reg(input logic [efp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      efp_pkg::CFG_START_RE:    cur_view.start_re = data;
      efp_pkg::CFG_START_IM:    cur_view.start_im = data;
      efp_pkg::CFG_STEP_RE:     cur_view.step_re = data;
      efp_pkg::CFG_STEP_IM:     cur_view.step_im = data;
      efp_pkg::CFG_MAX_ITER:    cur_view.max_iter = data[15:0];
      efp_pkg::CFG_BAILOUT:     cur_view.bailout = data;
      efp_pkg::CFG_COLOR_SCALE: cur_view.color_scale = data;
      efp_pkg::CFG_MODE:        cur_view.julia = data[0];
      default: ;
    endcase
    if (last) begin
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic load_view(input view_cfg_t v);
    write_reg(efp_pkg::CFG_START_RE, v.start_re, 1'b0);
    write_reg(efp_pkg::CFG_START_IM, v.start_im, 1'b0);
    write_reg(efp_pkg::CFG_STEP_RE, v.step_re, 1'b0);
    write_reg(efp_pkg::CFG_STEP_IM, v.step_im, 1'b0);
    write_reg(efp_pkg::CFG_MAX_ITER, {16'd0, v.max_iter}, 1'b0);
    write_reg(efp_pkg::CFG_BAILOUT, v.bailout, 1'b0);
    write_reg(efp_pkg::CFG_COLOR_SCALE, v.color_scale, 1'b0);
    write_reg(efp_pkg::CFG_MODE, {31'd0, v.julia}, 1'b1);
  endtask

  // Valid is left high after the transfer so that back-to-back pixels need no gap.
  task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_pixels.push_back(escape_pixel(cur_view, col, row));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_view();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    view_cfg_t v;
    v = '{start_re: 32'h7FFF_FFFF, start_im: 32'h8000_0000, step_re: 32'h7FFF_FFFF,
          step_im: 32'h7FFF_FFFF, max_iter: 16'hFFFF, bailout: 32'd0,
          color_scale: 32'hFFFF_FFFF, julia: 1'b1};
    load_view(v);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd1);
    wait_drained();
    v = '{start_re: 32'h8000_0000, start_im: 32'h7FFF_FFFF, step_re: 32'h8000_0000,
          step_im: 32'h8000_0000, max_iter: 16'd0, bailout: 32'hFFFF_FFFF,
          color_scale: 32'd0, julia: 1'b0};
    load_view(v);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd5, 10'd9);
    wait_drained();
  endtask

  task automatic test_unmapped_index();
    write_reg(IDX_UNMAPPED_LO, $urandom(), 1'b0);
    write_reg(IDX_UNMAPPED_HI, $urandom(), 1'b1);
    send_pixel(10'd7, 10'd300);
    send_pixel(10'd1000, 10'd2);
    wait_drained();
  endtask

  // Points just beyond the cusp escape after many iterations, so the full colour scale shows.
  task automatic test_slow_escape();
    view_cfg_t v;
    v = '{start_re: 32'sd69793218, start_im: 32'sd0, step_re: 32'sd1048576,
          step_im: 32'sd0, max_iter: 16'd1000, bailout: BAILOUT_FOUR,
          color_scale: 32'hFFFF_FFFF, julia: 1'b0};
    load_view(v);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd3, 10'd700);
    send_pixel(10'd40, 10'd1023);
    wait_drained();
  endtask

  task automatic test_random_views(input int unsigned phases, input int unsigned per_phase);
    for (int unsigned p = 0; p < phases; p++) begin
      idle_on <= ($urandom_range(0, 3) != 0);
      load_view(random_view());
      repeat (per_phase) send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      wait_drained();
    end
    idle_on <= 1'b1;
  endtask

  // The receiver stops for a long stretch while pixels keep coming, so the unit's
  // input stalls; afterwards the sender waits for every result before going on.
  task automatic test_backpressure();
    view_cfg_t v;
    v = RESET_VIEW;
    v.max_iter = 16'd20;
    load_view(v);
    rx_hold_req <= HOLD_OFF_CYCLES;
    repeat (24) send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    wait_drained();
    repeat (16) send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    wait_drained();
  endtask

  task automatic test_unbroken_stream();
    view_cfg_t v;
    idle_on <= 1'b0;
    v = random_view();
    v.max_iter = 16'($urandom_range(0, 60));
    load_view(v);
    repeat (120) send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_left <= rx_hold_req;
      rx_hold_req <= 0;
      out_tready <= 1'b0;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && rst_n && $urandom_range(0, 15) == 0) begin
      rx_left <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("result transfer with no pixel outstanding: out_tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[31:0] !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[47:32] !== want.count) begin
          $error("escape_count: expected %0d, got %0d", want.count, out_tdata[47:32]);
          fail_count++;
        end
        if (out_tdata[48] !== want.escaped) begin
          $error("escaped: expected %b, got %b", want.escaped, out_tdata[48]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_register_extremes();
    test_unmapped_index();
    test_slow_escape();
    test_random_views(14, 70);
    test_backpressure();
    test_unbroken_stream();
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/efp_pkg.sv
design/efp_cfg_regs.sv
design/efp_mult.sv
design/efp_engine.sv
design/escape_time_fractal_pixel_unit.sv
tb/tb_top.sv
